### hdl/b2d_pkg.sv
`timescale 1ns / 1ps

package b2d_pkg;

  localparam int VALUE_W    = 32;
  localparam int ASCII_W    = 6;
  localparam int DIGIT_W    = 4;
  localparam int NUM_POWERS = 10;
  localparam int IDX_W      = $clog2(NUM_POWERS);

  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_POWERS - 1);
  localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [VALUE_W-1:0] POW_TEN [NUM_POWERS] = '{
    32'd1000000000, 32'd100000000, 32'd10000000, 32'd1000000, 32'd100000,
    32'd10000, 32'd1000, 32'd100, 32'd10, 32'd1
  };

  // Queue entry: the value and whether it is a single digit.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_small;
  } b2d_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } b2d_qstat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } b2d_state_t;

endpackage

### hdl/b2d_front.sv
`timescale 1ns / 1ps

module b2d_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [b2d_pkg::VALUE_W-1:0] value,
  input  b2d_pkg::b2d_qstat_t        qstat,
  output logic                       push,
  output b2d_pkg::b2d_entry_t        push_entry
);
  import b2d_pkg::*;

  logic       f_valid;
  b2d_entry_t f_entry;
  logic       accept;

  assign push       = f_valid && !qstat.full;
  assign push_entry = f_entry;
  assign in_stall   = f_valid && qstat.full;
  assign accept     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry.value    <= value;
      f_entry.is_small <= (value < POW_TEN[LAST_IDX - 1'b1]);
    end
  end

endmodule

### hdl/b2d_queue.sv
`timescale 1ns / 1ps

module b2d_queue #(
  parameter int DEPTH = b2d_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b2d_pkg::b2d_entry_t push_entry,
  input  logic                pop,
  output b2d_pkg::b2d_entry_t head,
  output b2d_pkg::b2d_qstat_t qstat
);
  import b2d_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  b2d_entry_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign qstat.full  = (count == FULL_CNT);
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count out of range");

endmodule

### hdl/b2d_back.sv
`timescale 1ns / 1ps

module b2d_back (
  input  logic                        clk,
  input  logic                        rst,
  input  b2d_pkg::b2d_qstat_t         qstat,
  input  b2d_pkg::b2d_entry_t         head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [b2d_pkg::ASCII_W-1:0] ascii_digit,
  output logic                        last_digit
);
  import b2d_pkg::*;

  b2d_state_t           state;
  logic [VALUE_W-1:0]   rem;
  logic [IDX_W-1:0]     pidx;
  logic [DIGIT_W-1:0]   digit;
  logic                 seen;
  logic [VALUE_W:0]     diff;
  logic                 fits;
  logic                 need_emit;
  logic                 out_free;
  logic                 emit;
  logic                 advance;

  assign diff      = {1'b0, rem} - {1'b0, POW_TEN[pidx]};
  assign fits      = !diff[VALUE_W];
  assign need_emit = (digit != '0) || seen || (pidx == LAST_IDX);
  assign out_free  = !out_valid || !out_stall;
  assign advance   = (state == ST_RUN) && !fits && (!need_emit || out_free);
  assign emit      = advance && need_emit;
  assign pop       = (state == ST_IDLE) && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (advance && pidx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem   <= head.value;
      pidx  <= head.is_small ? LAST_IDX : '0;
      digit <= '0;
      seen  <= 1'b0;
    end else if (state == ST_RUN) begin
      if (fits) begin
        rem   <= diff[VALUE_W-1:0];
        digit <= digit + 1'b1;
      end else if (advance) begin
        pidx  <= pidx + 1'b1;
        digit <= '0;
        seen  <= need_emit;
      end
    end
    if (emit) begin
      ascii_digit <= ASCII_ZERO | {{(ASCII_W-DIGIT_W){1'b0}}, digit};
      last_digit  <= (pidx == LAST_IDX);
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> pidx <= LAST_IDX)
    else $error("power index out of range");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> digit <= DIGIT_MAX)
    else $error("digit above nine");

endmodule

### hdl/binary_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps

// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | value[31:0]
// out     | out_valid | out_stall | ascii_digit[5:0], last_digit
//
// The subtractor works on one value at a time, one subtract-and-compare per cycle
// unless a stalled output beat holds it.
// Values below ten skip straight to the units position.
// The front stage and queue take new values while the back converts.
// rst is synchronous; it empties the front stage, queue and output beat.
// A stalled output beat holds the back; a full queue with the front stage occupied stalls the input.
module binary_to_decimal_ascii_unit #(
  parameter int QUEUE_DEPTH = b2d_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [b2d_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [b2d_pkg::ASCII_W-1:0] ascii_digit,
  output logic                        last_digit
);
  import b2d_pkg::*;

  b2d_qstat_t qstat;
  b2d_entry_t push_entry;
  b2d_entry_t head;
  logic       push;
  logic       pop;

  b2d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  b2d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  b2d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ascii_digit (ascii_digit),
    .last_digit  (last_digit)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import b2d_pkg::*;

  localparam int RANDOM_VALUES = 196;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int DRAIN_CYCLES  = 120;
  localparam int HOLD_CYCLES   = 600;

  typedef struct {
    logic [ASCII_W-1:0] code;
    logic               is_units;
  } dec_char_t;

  class decimal_text_board;
    dec_char_t pending_chars[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    // Digits by repeated subtraction of each power of ten, leading zeros dropped.
    function void queue_decimal_text(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] rem;
      logic [DIGIT_W-1:0] d;
      bit                 started;
      dec_char_t          c;
      rem = v;
      started = 1'b0;
      for (int p = 0; p < NUM_POWERS; p++) begin
        d = '0;
        while (rem >= POW_TEN[p]) begin
          rem = rem - POW_TEN[p];
          d = d + 1'b1;
        end
        if (d != 0 || started || p == NUM_POWERS - 1) begin
          started = 1'b1;
          c.code = ASCII_ZERO + {{(ASCII_W - DIGIT_W){1'b0}}, d};
          c.is_units = (p == NUM_POWERS - 1);
          pending_chars.push_back(c);
        end
      end
    endfunction

    task check_char(logic [ASCII_W-1:0] code, logic is_units);
      dec_char_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected beat ascii_digit=%0d last_digit=%0b", code, is_units));
      end else begin
        want = pending_chars.pop_front();
        if (code !== want.code)
          report($sformatf("ascii_digit got %0d want %0d", code, want.code));
        if (is_units !== want.is_units)
          report($sformatf("last_digit got %0b want %0b", is_units, want.is_units));
      end
    endtask

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [ASCII_W-1:0] ascii_digit;
  logic               last_digit;

  logic steady;
  logic long_hold;
  int   values_sent;
  int   cycle_count;

  decimal_text_board board;

  logic [VALUE_W-1:0] corner_values [24] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
    32'd9999, 32'd10000, 32'd99999999, 32'd100000000, 32'd999999999,
    32'd1000000000, 32'd1000000001, 32'd1999999999, 32'd2147483648,
    32'd3999999999, 32'd4000000000, 32'd4294967294, 32'd4294967295,
    32'hAAAAAAAA, 32'h55555555, 32'd1234567890
  };

  binary_to_decimal_ascii_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ascii_digit (ascii_digit),
    .last_digit  (last_digit)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("binary_to_decimal_ascii_unit verification failed");
      $finish;
    end
  end

  // Mostly short idles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(1, 31);
      2: v = $urandom_range(0, 20);
      default: v = POW_TEN[$urandom_range(0, NUM_POWERS - 1)] + $urandom_range(0, 2) - 1;
    endcase
    return v;
  endfunction

  task send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (in_stall);
    board.queue_decimal_text(v);
    values_sent <= values_sent + 1;
  endtask

  // Receiver: check accepted beats, then choose the next stall.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (out_valid && !out_stall)
        board.check_char(ascii_digit, last_digit);
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!steady) stall_left = pick_gap();
      end
      @(posedge clk);
    end
  end

  // Back-pressure: hold the output off long enough for the input to stall.
  initial begin
    long_hold <= 1'b0;
    do @(posedge clk); while (values_sent < 40);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    board = new();
    cycle_count = 0;
    values_sent = 0;
    steady <= 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_values[i]) send_value(corner_values[i]);

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      steady <= ((i / 40) % 2 == 1);
      send_value(random_value());
    end
    in_valid <= 1'b0;
    steady <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0)
      $display("binary_to_decimal_ascii_unit verification clean");
    else
      $display("binary_to_decimal_ascii_unit verification failed");
    $finish;
  end

endmodule

### files.f
hdl/b2d_pkg.sv
hdl/b2d_front.sv
hdl/b2d_queue.sv
hdl/b2d_back.sv
hdl/binary_to_decimal_ascii_unit.sv
tb/sv/tb.sv
